// File: src/sed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the string escape decoder.
// No dependencies; imported by every module of the block.
package sed_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
        logic [1:0] status;
    } out_t;

    localparam int MaxRes   = 5;
    localparam int ResIdxW  = $clog2(MaxRes + 1);
    localparam int PktDepth = 4;
    localparam int PktPtrW  = $clog2(PktDepth);

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] status;
    } slot_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [ResIdxW-1:0]       count;
        logic                     last;
        slot_t [MaxRes-1:0]       slot;
    } pkt_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_UNI = 2'd1;
    localparam logic [1:0] STATUS_BAD_ESC = 2'd2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

endpackage

// File: src/sed_front.sv
`timescale 1ns / 1ps
// Parser: takes one raw byte per request and builds the packet of results it causes.
// Depends on sed_pkg.
module sed_front
    import sed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  item,
    output pkt_t pkt,
    output logic pkt_push
);

    typedef enum logic [6:0] {
        M_PLAIN   = 7'b0000001,
        M_ESC     = 7'b0000010,
        M_HEX1    = 7'b0000100,
        M_HIGH    = 7'b0001000,
        M_HIGH_BS = 7'b0010000,
        M_HEX2    = 7'b0100000,
        M_DROP    = 7'b1000000
    } mode_t;

    function automatic pkt_t pkt_add(pkt_t p, logic [7:0] b, logic v, logic [1:0] s);
        pkt_t r;
        r = p;
        if (p.count < ResIdxW'(MaxRes))
        begin
            r.slot[p.count] = '{data: b, valid: v, status: s};
            r.count = p.count + ResIdxW'(1);
        end
        return r;
    endfunction

    function automatic pkt_t emit_bmp(pkt_t p, logic [15:0] cp);
        pkt_t r;
        r = p;
        if (cp[15:11] == 5'b11011)
        begin
            r = pkt_add(r, CH_QMARK, 1'b1, STATUS_OK);
        end
        else if (cp < 16'h0080)
        begin
            r = pkt_add(r, cp[7:0], 1'b1, STATUS_OK);
        end
        else if (cp < 16'h0800)
        begin
            r = pkt_add(r, {3'b110, cp[10:6]}, 1'b1, STATUS_OK);
            r = pkt_add(r, {2'b10, cp[5:0]}, 1'b1, STATUS_OK);
        end
        else
        begin
            r = pkt_add(r, {4'b1110, cp[15:12]}, 1'b1, STATUS_OK);
            r = pkt_add(r, {2'b10, cp[11:6]}, 1'b1, STATUS_OK);
            r = pkt_add(r, {2'b10, cp[5:0]}, 1'b1, STATUS_OK);
        end
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  hi_reg, hi_next;
    logic [1:0]  err_reg, err_next;

    logic [7:0]  c;
    logic        last;
    logic        is_digit, is_letter, hex_ok;
    logic [3:0]  d;
    logic [15:0] cp;
    logic        esc_ok, esc_u;
    logic [7:0]  esc_b;
    logic        do_esc;
    logic [4:0]  plane;
    pkt_t        p;

    assign c    = item.in_byte;
    assign last = item.in_last;

    assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
    assign is_letter = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    assign hex_ok    = is_digit || is_letter;
    assign d         = is_digit ? c[3:0] : (c[3:0] + 4'd9);
    assign cp        = {acc_reg, d};
    assign plane     = {1'b0, hi_reg[9:6]} + 5'd1;

    always_comb
    begin
        esc_ok = 1'b1;
        esc_u  = 1'b0;
        esc_b  = c;
        unique case (c)
            8'h6E: esc_b = 8'h0A;
            8'h74: esc_b = 8'h09;
            8'h72: esc_b = 8'h0D;
            8'h5C: esc_b = 8'h5C;
            8'h22: esc_b = 8'h22;
            8'h61: esc_b = 8'h07;
            8'h76: esc_b = 8'h0B;
            8'h3F: esc_b = 8'h3F;
            8'h66: esc_b = 8'h0C;
            8'h62: esc_b = 8'h08;
            8'h75: esc_u = 1'b1;
            default: esc_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        p         = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        hi_next   = hi_reg;
        err_next  = err_reg;
        do_esc    = 1'b0;

        unique case (mode_reg) inside
            M_PLAIN:
            begin
                if (c == CH_BSLASH)
                    mode_next = M_ESC;
                else
                    p = pkt_add(p, c, 1'b1, STATUS_OK);
            end
            M_ESC:
            begin
                do_esc = 1'b1;
            end
            M_HEX1, M_HEX2:
            begin
                if (!hex_ok)
                begin
                    p         = pkt_add(p, 8'h00, 1'b0, STATUS_BAD_UNI);
                    err_next  = STATUS_BAD_UNI;
                    mode_next = M_DROP;
                end
                else
                begin
                    acc_next = {acc_reg[7:0], d};
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        if (mode_reg == M_HEX1)
                        begin
                            if (cp[15:10] == 6'b110110)
                            begin
                                hi_next   = cp[9:0];
                                mode_next = M_HIGH;
                            end
                            else
                            begin
                                mode_next = M_PLAIN;
                                p = emit_bmp(p, cp);
                            end
                        end
                        else
                        begin
                            mode_next = M_PLAIN;
                            if (cp[15:10] == 6'b110111)
                            begin
                                p = pkt_add(p, {5'b11110, plane[4:2]}, 1'b1, STATUS_OK);
                                p = pkt_add(p, {2'b10, plane[1:0], hi_reg[5:2]}, 1'b1,
                                            STATUS_OK);
                                p = pkt_add(p, {2'b10, hi_reg[1:0], cp[9:6]}, 1'b1,
                                            STATUS_OK);
                                p = pkt_add(p, {2'b10, cp[5:0]}, 1'b1, STATUS_OK);
                            end
                            else
                            begin
                                p = pkt_add(p, CH_QMARK, 1'b1, STATUS_OK);
                                p = emit_bmp(p, cp);
                            end
                        end
                    end
                end
            end
            M_HIGH:
            begin
                if (c == CH_BSLASH)
                    mode_next = M_HIGH_BS;
                else
                begin
                    p         = pkt_add(p, CH_QMARK, 1'b1, STATUS_OK);
                    p         = pkt_add(p, c, 1'b1, STATUS_OK);
                    mode_next = M_PLAIN;
                end
            end
            M_HIGH_BS:
            begin
                if (c == CH_U)
                begin
                    mode_next = M_HEX2;
                    cnt_next  = 2'd0;
                    acc_next  = '0;
                end
                else
                begin
                    p      = pkt_add(p, CH_QMARK, 1'b1, STATUS_OK);
                    do_esc = 1'b1;
                end
            end
            M_DROP:
            begin
            end
            default:
            begin
            end
        endcase

        if (do_esc)
        begin
            mode_next = M_PLAIN;
            if (esc_u)
            begin
                mode_next = M_HEX1;
                cnt_next  = 2'd0;
                acc_next  = '0;
            end
            else if (esc_ok)
                p = pkt_add(p, esc_b, 1'b1, STATUS_OK);
            else
            begin
                p         = pkt_add(p, 8'h00, 1'b0, STATUS_BAD_ESC);
                err_next  = STATUS_BAD_ESC;
                mode_next = M_DROP;
            end
        end

        if (last)
        begin
            if (mode_next inside {M_HEX1, M_HEX2})
            begin
                p        = pkt_add(p, 8'h00, 1'b0, STATUS_BAD_UNI);
                err_next = STATUS_BAD_UNI;
            end
            else if (mode_next inside {M_HIGH, M_HIGH_BS})
                p = pkt_add(p, CH_QMARK, 1'b1, STATUS_OK);
            if (p.count == '0)
                p = pkt_add(p, 8'h00, 1'b0, err_next);
        end
        p.last = last;
    end

    assign pkt      = p;
    assign pkt_push = accept && (p.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            hi_reg   <= '0;
            err_reg  <= STATUS_OK;
        end
        else if (accept)
        begin
            if (last)
            begin
                mode_reg <= M_PLAIN;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                hi_reg   <= '0;
                err_reg  <= STATUS_OK;
            end
            else
            begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                acc_reg  <= acc_next;
                hi_reg   <= hi_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

// File: src/sed_pkt_fifo.sv
`timescale 1ns / 1ps
// Short packet queue between the parser and the result serializer.
// Depends on sed_pkg.
module sed_pkt_fifo
    import sed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  pkt_t wr_data,
    input  logic rd_en,
    output pkt_t rd_data,
    output logic full,
    output logic avail
);

    pkt_t               mem_reg [PktDepth];
    logic [PktPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PktPtrW:0]   count_reg;

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == (PktPtrW + 1)'(PktDepth));
    assign avail   = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PktPtrW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PktPtrW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (PktPtrW + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (PktPtrW + 1)'(1);
        end
    end

endmodule

// File: src/sed_back.sv
`timescale 1ns / 1ps
// Serializer: walks the head packet one result per cycle into the output register while it is empty or popped.
// Depends on sed_pkg.
module sed_back
    import sed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  pkt_t pkt,
    input  logic pkt_avail,
    output logic pkt_pop,
    output out_t result,
    output logic empty,
    input  logic pop
);

    logic [ResIdxW-1:0] idx_reg;
    logic [ResIdxW-1:0] last_idx;
    logic               at_last, load;
    slot_t              cur;
    out_t               result_reg, result_next;
    logic               valid_reg;

    assign last_idx = pkt.count - ResIdxW'(1);
    assign at_last  = (idx_reg == last_idx);
    assign cur      = pkt.slot[idx_reg];
    assign load     = pkt_avail && (!valid_reg || pop);
    assign pkt_pop  = load && at_last;

    assign result_next = '{out_byte:   cur.data,
                           byte_valid: cur.valid,
                           run_last:   at_last,
                           string_end: at_last && pkt.last,
                           status:     cur.status};

    assign result = result_reg;
    assign empty  = !valid_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? '0 : idx_reg + ResIdxW'(1);
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

endmodule

// File: src/string_escape_decoder_utf8.sv
`timescale 1ns / 1ps
// Top level of the string escape decoder: parser, packet queue and serializer.
// Depends on sed_pkg, sed_front, sed_pkt_fifo and sed_back.

// One escaped byte is taken per cycle while full is low; the parser turns it into a packet
// of zero to four results in the same cycle and writes any non-empty one to a four-entry packet queue.
// Results leave one per cycle from an output register while pop keeps it free, so a byte
// that yields several results (UTF-8 sequences, a '?' before a broken surrogate pair)
// holds the result side until each has left, and full rises only once four packets wait.
// A result reaches the ports by way of the packet queue and then the output register.
module string_escape_decoder_utf8
    import sed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic empty,
    input  logic pop,
    output out_t result
);

    logic accept;
    pkt_t wr_pkt, rd_pkt;
    logic wr_en, rd_en, avail;

    assign accept = push && !full;

    sed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .pkt      (wr_pkt),
        .pkt_push (wr_en)
    );

    sed_pkt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_pkt),
        .rd_en   (rd_en),
        .rd_data (rd_pkt),
        .full    (full),
        .avail   (avail)
    );

    sed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (rd_pkt),
        .pkt_avail (avail),
        .pkt_pop   (rd_en),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_escape_decoder_utf8: escaped strings in, decoded bytes out.
// Depends on sed_pkg and the decoder RTL; a scoreboard class predicts and checks every result.

module tb;
    import sed_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 270;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_B     = 8'h62;

    typedef enum logic [2:0] {
        TEXT, ESCAPE, HEX_FIRST, GOT_HIGH, GOT_HIGH_BSLASH, HEX_SECOND, SKIP
    } parse_e;

    class unescape_checker;
        parse_e      mode;
        logic [2:0]  digits;
        logic [15:0] high_unit;
        logic [15:0] acc;
        logic [1:0]  err_code;
        out_t        burst[MaxRes];
        int          burst_len;
        out_t        decoded_q[$];
        int          mismatches;
        int          checked;

        function new();
            mismatches = 0;
            checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = TEXT;
            digits = '0;
            high_unit = '0;
            acc = '0;
            err_code = STATUS_OK;
        endfunction

        function int waiting();
            return decoded_q.size();
        endfunction

        function void append(logic [7:0] b, logic v, logic [1:0] st);
            out_t r;
            r = '0;
            r.out_byte = b;
            r.byte_valid = v;
            r.status = st;
            if (burst_len < MaxRes) begin
                burst[burst_len] = r;
                burst_len++;
            end
        endfunction

        function void abort(logic [1:0] code);
            append(8'h00, 1'b0, code);
            err_code = code;
            mode = SKIP;
        endfunction

        function int nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
            if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
            if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
            return -1;
        endfunction

        function void put_bmp(logic [15:0] cp);
            if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
                append(CH_QMARK, 1'b1, STATUS_OK);
            end else if (cp < 16'h0080) begin
                append(cp[7:0], 1'b1, STATUS_OK);
            end else if (cp < 16'h0800) begin
                append({3'b110, cp[10:6]}, 1'b1, STATUS_OK);
                append({2'b10, cp[5:0]}, 1'b1, STATUS_OK);
            end else begin
                append({4'b1110, cp[15:12]}, 1'b1, STATUS_OK);
                append({2'b10, cp[11:6]}, 1'b1, STATUS_OK);
                append({2'b10, cp[5:0]}, 1'b1, STATUS_OK);
            end
        endfunction

        function void text_byte(logic [7:0] c);
            if (c == CH_BSLASH)
                mode = ESCAPE;
            else
                append(c, 1'b1, STATUS_OK);
        endfunction

        function void begin_hex(parse_e m);
            mode = m;
            digits = '0;
            acc = '0;
        endfunction

        function void escape_byte(logic [7:0] c);
            mode = TEXT;
            case (c)
                CH_N:      append(8'h0A, 1'b1, STATUS_OK);
                CH_T:      append(8'h09, 1'b1, STATUS_OK);
                CH_R:      append(8'h0D, 1'b1, STATUS_OK);
                CH_BSLASH: append(CH_BSLASH, 1'b1, STATUS_OK);
                CH_DQUOTE: append(CH_DQUOTE, 1'b1, STATUS_OK);
                CH_A:      append(8'h07, 1'b1, STATUS_OK);
                CH_V:      append(8'h0B, 1'b1, STATUS_OK);
                CH_QMARK:  append(CH_QMARK, 1'b1, STATUS_OK);
                CH_F:      append(8'h0C, 1'b1, STATUS_OK);
                CH_B:      append(8'h08, 1'b1, STATUS_OK);
                CH_U:      begin_hex(HEX_FIRST);
                default:   abort(STATUS_BAD_ESC);
            endcase
        endfunction

        function void hex_byte(logic [7:0] c);
            int d;
            logic [20:0] cp;
            d = nibble(c);
            if (d < 0) begin
                abort(STATUS_BAD_UNI);
                return;
            end
            acc = {acc[11:0], d[3:0]};
            digits = digits + 3'd1;
            if (digits < 3'd4)
                return;
            if (mode == HEX_FIRST) begin
                if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                    high_unit = acc;
                    mode = GOT_HIGH;
                end else begin
                    mode = TEXT;
                    put_bmp(acc);
                end
            end else begin
                mode = TEXT;
                if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                    cp = 21'h10000 + {1'b0, high_unit[9:0], acc[9:0]};
                    append({5'b11110, cp[20:18]}, 1'b1, STATUS_OK);
                    append({2'b10, cp[17:12]}, 1'b1, STATUS_OK);
                    append({2'b10, cp[11:6]}, 1'b1, STATUS_OK);
                    append({2'b10, cp[5:0]}, 1'b1, STATUS_OK);
                end else begin
                    append(CH_QMARK, 1'b1, STATUS_OK);
                    put_bmp(acc);
                end
            end
        endfunction

        function void note_request(in_t req);
            logic [7:0] c;
            c = req.in_byte;
            burst_len = 0;
            case (mode)
                TEXT:                  text_byte(c);
                ESCAPE:                escape_byte(c);
                HEX_FIRST, HEX_SECOND: hex_byte(c);
                GOT_HIGH: begin
                    if (c == CH_BSLASH) begin
                        mode = GOT_HIGH_BSLASH;
                    end else begin
                        append(CH_QMARK, 1'b1, STATUS_OK);
                        mode = TEXT;
                        text_byte(c);
                    end
                end
                GOT_HIGH_BSLASH: begin
                    if (c == CH_U) begin
                        begin_hex(HEX_SECOND);
                    end else begin
                        append(CH_QMARK, 1'b1, STATUS_OK);
                        escape_byte(c);
                    end
                end
                default: ;
            endcase
            if (req.in_last) begin
                if (mode == HEX_FIRST || mode == HEX_SECOND)
                    abort(STATUS_BAD_UNI);
                else if (mode == GOT_HIGH || mode == GOT_HIGH_BSLASH)
                    append(CH_QMARK, 1'b1, STATUS_OK);
                if (burst_len == 0)
                    append(8'h00, 1'b0, err_code);
            end
            if (burst_len > 0) begin
                burst[burst_len-1].run_last = 1'b1;
                burst[burst_len-1].string_end = req.in_last;
            end
            for (int i = 0; i < burst_len; i++)
                decoded_q.push_back(burst[i]);
            if (req.in_last)
                clear_state();
        endfunction

        task report(string field, int got, int want);
            mismatches++;
            if (mismatches <= 40)
                $display("ERROR result %0d %s: got %0h, want %0h", checked, field, got, want);
        endtask

        task check_result(out_t got);
            out_t want;
            checked++;
            if (decoded_q.size() == 0) begin
                report("with no request pending", got, 0);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid !== want.byte_valid)
                report("byte_valid", got.byte_valid, want.byte_valid);
            if (got.run_last !== want.run_last)
                report("run_last", got.run_last, want.run_last);
            if (got.string_end !== want.string_end)
                report("string_end", got.string_end, want.string_end);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t  item;
    logic empty;
    logic pop;
    out_t result;

    unescape_checker board;
    logic [7:0]      text_q[$];
    int              sent;
    int              cycles;
    bit              hold_rx;
    bit              steady;

    string_escape_decoder_utf8 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic bit is_escape(logic [7:0] c);
        return c == CH_N || c == CH_T || c == CH_R || c == CH_BSLASH || c == CH_DQUOTE ||
               c == CH_A || c == CH_V || c == CH_QMARK || c == CH_F || c == CH_B || c == CH_U;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    function automatic void add_unicode(logic [15:0] cp);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        text_q.push_back(hex_char(cp[15:12]));
        text_q.push_back(hex_char(cp[11:8]));
        text_q.push_back(hex_char(cp[7:4]));
        text_q.push_back(hex_char(cp[3:0]));
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
            3:       return 16'($urandom_range(16'hD800, 16'hDBFF));
            4:       return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH)
            b = 8'h41;
        return b;
    endfunction

    function automatic logic [7:0] escape_char();
        logic [7:0] set[10];
        set = '{CH_N, CH_T, CH_R, CH_BSLASH, CH_DQUOTE, CH_A, CH_V, CH_QMARK, CH_F, CH_B};
        return set[$urandom_range(0, 9)];
    endfunction

    function automatic void add_piece();
        logic [7:0] b;
        int n;
        case ($urandom_range(0, 15))
            0, 1, 2: text_q.push_back(plain_char());
            3, 4: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(escape_char());
            end
            5, 6, 7: add_unicode(pick_code());
            8, 9: begin
                add_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            10, 11: begin
                add_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                case ($urandom_range(0, 3))
                    0: text_q.push_back(plain_char());
                    1: begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(escape_char());
                    end
                    2: add_unicode(pick_code());
                    default: ;
                endcase
            end
            12: begin
                do b = 8'($urandom_range(0, 255)); while (is_escape(b));
                text_q.push_back(CH_BSLASH);
                text_q.push_back(b);
            end
            13: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_U);
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                do b = 8'($urandom_range(0, 255)); while (is_hex(b));
                text_q.push_back(b);
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_string();
        int pieces;
        int cut;
        text_q.delete();
        pieces = $urandom_range(1, 5);
        repeat (pieces) add_piece();
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && text_q.size() > 1) begin
                void'(text_q.pop_back());
                cut--;
            end
        end
        if ($urandom_range(0, 15) == 0)
            text_q.push_back(CH_BSLASH);
    endfunction

    task automatic send_request(logic [7:0] b, logic last);
        in_t req;
        int gap;
        req.in_byte = b;
        req.in_last = last;
        @(negedge clk);
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_request(req);
        sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            push <= 1'b0;
            item <= in_t'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < text_q.size(); i++)
            send_request(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic drain();
        while (board.waiting() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        bit held;
        bit paused;
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        sent = 0;
        cycles = 0;
        hold_rx = 1'b0;
        steady = 1'b0;
        held = 1'b0;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        text_q = '{8'h00, 8'hFF};
        send_string();
        text_q.delete();
        add_unicode(16'hDBFF);
        add_unicode(16'hDFFF);
        send_string();
        text_q.delete();
        add_unicode(16'hD800);
        text_q.push_back(8'h41);
        send_string();
        text_q = '{CH_BSLASH, 8'h71, 8'h7A};
        send_string();
        text_q = '{CH_BSLASH};
        send_string();
        text_q = '{CH_BSLASH, CH_U, 8'h31};
        send_string();
        @(negedge clk);
        push <= 1'b0;
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!held && sent > 80) begin
                held = 1'b1;
                hold_rx = 1'b1;
            end
            if (!paused && sent > 180) begin
                paused = 1'b1;
                @(negedge clk);
                push <= 1'b0;
                drain();
            end
            steady = ($urandom_range(0, 3) == 0);
            build_string();
            send_string();
        end
        @(negedge clk);
        push <= 1'b0;
        drain();

        if (board.mismatches == 0 && board.waiting() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int stall;
        int calm;
        int r;
        pop = 1'b0;
        stall = 0;
        calm = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                stall = HOLD_CYCLES;
                calm = 0;
            end else if (stall == 0 && calm > 0) begin
                calm--;
            end else if (stall == 0) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    calm = $urandom_range(20, 80);
                else if (r < 70)
                    stall = 0;
                else if (r < 96)
                    stall = $urandom_range(1, 3);
                else
                    stall = $urandom_range(10, 50);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
            @(posedge clk);
            if (pop && !empty)
                board.check_result(result);
        end
    end

endmodule
